>>> src/lin_frame_transmitter_macros.svh
// Assertion macros shared by the LIN frame transmitter RTL.
`ifndef LIN_FRAME_TRANSMITTER_MACROS_SVH
`define LIN_FRAME_TRANSMITTER_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define LFT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Invariant that holds at every rising edge outside reset.
`define LFT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

>>> src/lft_pkg.sv
// Package for the LIN frame transmitter: codes, control word type and microprogram.
package lft_pkg;

  localparam int CFG_W   = 6;
  localparam int CNT_W   = 4;
  localparam int ADDR_W  = 3;
  localparam int DEPTH   = 8;
  localparam logic [CNT_W-1:0] MAX_PAYLOAD = 4'd8;
  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_ID   = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_LEN = 2'd1;
  localparam logic [1:0] REG_MASTER_SEND = 2'd2;

  // Input operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_BREAK = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Frame phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_BREAK = 7'b0000010,
    PH_SYNC  = 7'b0000100,
    PH_PID   = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_CSUM  = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  // Microprogram step addresses
  typedef logic [3:0] upc_t;
  localparam upc_t U_WAIT  = 4'd0;
  localparam upc_t U_DISP  = 4'd1;
  localparam upc_t U_LOAD  = 4'd2;
  localparam upc_t U_IDLE  = 4'd3;
  localparam upc_t U_BREAK = 4'd4;
  localparam upc_t U_SYNC  = 4'd5;
  localparam upc_t U_PID   = 4'd6;
  localparam upc_t U_DATA  = 4'd7;
  localparam upc_t U_SINIT = 4'd8;
  localparam upc_t U_SLOOP = 4'd9;
  localparam upc_t U_SEMIT = 4'd10;
  localparam upc_t U_DONE  = 4'd11;
  localparam upc_t U_BAD   = 4'd12;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_LOAD,
    ACT_IDLE,
    ACT_BREAK,
    ACT_SYNC,
    ACT_PID,
    ACT_DATA,
    ACT_SUM_INIT,
    ACT_SUM_STEP,
    ACT_SUM_EMIT,
    ACT_DONE,
    ACT_BAD
  } act_t;

  typedef enum logic [1:0] {
    J_GOTO,
    J_WAIT_IN,
    J_DISPATCH,
    J_LOOP
  } jmp_t;

  typedef struct packed {
    act_t act;
    jmp_t jmp;
    upc_t target;
    logic emit;
  } cword_t;

  // Control store: one word per step
  function automatic cword_t ucode(upc_t pc);
    cword_t w;
    w = '{act: ACT_NONE, jmp: J_GOTO, target: U_WAIT, emit: 1'b0};
    unique case (pc)
      U_WAIT:  w = '{act: ACT_LATCH,    jmp: J_WAIT_IN,  target: U_DISP,  emit: 1'b0};
      U_DISP:  w = '{act: ACT_NONE,     jmp: J_DISPATCH, target: U_WAIT,  emit: 1'b0};
      U_LOAD:  w = '{act: ACT_LOAD,     jmp: J_GOTO,     target: U_WAIT,  emit: 1'b0};
      U_IDLE:  w = '{act: ACT_IDLE,     jmp: J_GOTO,     target: U_WAIT,  emit: 1'b0};
      U_BREAK: w = '{act: ACT_BREAK,    jmp: J_GOTO,     target: U_WAIT,  emit: 1'b1};
      U_SYNC:  w = '{act: ACT_SYNC,     jmp: J_GOTO,     target: U_WAIT,  emit: 1'b1};
      U_PID:   w = '{act: ACT_PID,      jmp: J_GOTO,     target: U_WAIT,  emit: 1'b1};
      U_DATA:  w = '{act: ACT_DATA,     jmp: J_GOTO,     target: U_WAIT,  emit: 1'b1};
      U_SINIT: w = '{act: ACT_SUM_INIT, jmp: J_GOTO,     target: U_SLOOP, emit: 1'b0};
      U_SLOOP: w = '{act: ACT_SUM_STEP, jmp: J_LOOP,     target: U_SEMIT, emit: 1'b0};
      U_SEMIT: w = '{act: ACT_SUM_EMIT, jmp: J_GOTO,     target: U_WAIT,  emit: 1'b1};
      U_DONE:  w = '{act: ACT_DONE,     jmp: J_GOTO,     target: U_WAIT,  emit: 1'b1};
      U_BAD:   w = '{act: ACT_BAD,      jmp: J_GOTO,     target: U_WAIT,  emit: 1'b0};
      default: w = '{act: ACT_NONE,     jmp: J_GOTO,     target: U_WAIT,  emit: 1'b0};
    endcase
    return w;
  endfunction

  // Entry step of the microprogram for a tick in each phase
  function automatic upc_t phase_entry(phase_t ph);
    upc_t pc;
    unique case (ph)
      PH_IDLE:  pc = U_IDLE;
      PH_BREAK: pc = U_BREAK;
      PH_SYNC:  pc = U_SYNC;
      PH_PID:   pc = U_PID;
      PH_DATA:  pc = U_DATA;
      PH_CSUM:  pc = U_SINIT;
      PH_DONE:  pc = U_DONE;
      default:  pc = U_BAD;
    endcase
    return pc;
  endfunction

  // Six-bit identifier with P0 at bit 6 and P1 at bit 7
  function automatic logic [7:0] with_parity(logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

>>> src/lin_frame_transmitter.sv
// LIN master frame transmitter: microcoded frame sequencer with enhanced checksum.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       op, byte_index, byte_value
//   out      output     out_valid / out_ready     kind, tx_byte
//   cfg      input      cfg_we (write only)       cfg_index, cfg_data
//
// Each item takes one accept step plus one dispatch step plus its own steps: a load or a
// tick outside the checksum phase has one own step; the checksum tick runs an init step,
// the one-byte-per-cycle summing loop over the buffer, and an emit step.
// Reset clears the step counter, phase, counters and result register; the payload buffer
// is not cleared. A step that produces a result holds while the result register is full
// and not taken; the result register lets an item be accepted while a result waits.
module lin_frame_transmitter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [2:0]                byte_index,
  input  logic [7:0]                byte_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic [7:0]                tx_byte,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [lft_pkg::CFG_W-1:0] cfg_data
);
  import lft_pkg::*;

  `include "lin_frame_transmitter_macros.svh"

  // Configuration registers
  logic [5:0]       frame_identifier;
  logic [CNT_W-1:0] payload_length;
  logic             master_sends_data;

  // Sequencer and datapath state
  upc_t             upc;
  upc_t             upc_next;
  cword_t           cw;
  phase_t           frame_phase;
  logic [CNT_W-1:0] sent_count;
  logic [CNT_W-1:0] sum_idx;
  logic [7:0]       frame_pid;
  logic [7:0]       acc;
  logic             item_op;
  logic [2:0]       item_idx;
  logic [7:0]       item_val;
  logic [7:0]       payload_store [DEPTH];

  logic             in_xfer;
  logic             stall;
  logic             res_set;
  logic [CNT_W-1:0] eff_len;
  logic [CNT_W-1:0] cnt_inc;
  logic             data_more;
  logic             sum_more;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [8:0]       sum_wide;
  logic [7:0]       acc_add;

  assign cw       = ucode(upc);
  assign in_ready = (upc == U_WAIT);
  assign in_xfer  = in_valid && in_ready;
  assign stall    = cw.emit && out_valid && !out_ready;

  // Load the result register on an unblocked step that produces a result
  assign res_set  = !stall && cw.emit && ((cw.act != ACT_DATA) || data_more);

  // Clamp the length to the buffer depth
  assign eff_len   = (payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_length;
  assign cnt_inc   = sent_count + CNT_W'(1);
  assign data_more = (cnt_inc != '0) && (cnt_inc <= eff_len);
  assign sum_more  = (sum_idx < eff_len);

  // One buffer read port, shared by the data step and the summing loop
  assign rd_addr = (cw.act == ACT_DATA) ? ADDR_W'(cnt_inc - CNT_W'(1)) : sum_idx[ADDR_W-1:0];
  assign rd_data = payload_store[rd_addr];

  // Add with end-around carry
  assign sum_wide = {1'b0, acc} + {1'b0, rd_data};
  assign acc_add  = sum_wide[8] ? (sum_wide[7:0] + 8'd1) : sum_wide[7:0];

  // Next step address
  always_comb begin
    unique case (cw.jmp)
      J_WAIT_IN:  upc_next = in_xfer ? cw.target : upc;
      J_DISPATCH: upc_next = (item_op == OP_LOAD) ? U_LOAD : phase_entry(frame_phase);
      J_LOOP:     upc_next = sum_more ? upc : cw.target;
      J_GOTO:     upc_next = cw.target;
      default:    upc_next = U_WAIT;
    endcase
    if (stall) begin
      upc_next = upc;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_identifier  <= '0;
      payload_length    <= '0;
      master_sends_data <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_ID:    frame_identifier  <= cfg_data[5:0];
        REG_PAYLOAD_LEN: payload_length    <= cfg_data[CNT_W-1:0];
        REG_MASTER_SEND: master_sends_data <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Payload buffer
  always_ff @(posedge clk) begin
    if (cw.act == ACT_LOAD) begin
      payload_store[item_idx] <= item_val;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_op  <= op;
      item_idx <= byte_index;
      item_val <= byte_value;
    end
  end

  // Step counter, phase, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= U_WAIT;
      frame_phase  <= PH_IDLE;
      sent_count   <= '0;
      sum_idx      <= '0;
      frame_pid    <= '0;
      acc          <= '0;
      out_valid    <= 1'b0;
      kind         <= KIND_BREAK;
      tx_byte      <= '0;
    end else begin
      upc <= upc_next;
      // load a new result, or drop the current one once transferred
      if (res_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (!stall) begin
        unique case (cw.act)
          ACT_IDLE: begin
            frame_phase <= PH_BREAK;
          end
          ACT_BREAK: begin
            frame_phase <= PH_SYNC;
            kind        <= KIND_BREAK;
            tx_byte     <= '0;
          end
          ACT_SYNC: begin
            frame_phase <= PH_PID;
            kind        <= KIND_BYTE;
            tx_byte     <= SYNC_BYTE;
          end
          ACT_PID: begin
            frame_pid    <= with_parity(frame_identifier);
            frame_phase  <= master_sends_data ? PH_DATA : PH_DONE;
            kind         <= KIND_BYTE;
            tx_byte      <= with_parity(frame_identifier);
          end
          ACT_DATA: begin
            if (data_more) begin
              sent_count <= cnt_inc;
              kind       <= KIND_BYTE;
              tx_byte    <= rd_data;
            end else begin
              sent_count  <= '0;
              frame_phase <= PH_CSUM;
            end
          end
          ACT_SUM_INIT: begin
            acc     <= frame_pid;
            sum_idx <= '0;
          end
          ACT_SUM_STEP: begin
            if (sum_more) begin
              acc     <= acc_add;
              sum_idx <= sum_idx + CNT_W'(1);
            end
          end
          ACT_SUM_EMIT: begin
            frame_phase <= PH_DONE;
            kind        <= KIND_BYTE;
            tx_byte     <= ~acc;
          end
          ACT_DONE: begin
            frame_phase <= PH_IDLE;
            kind        <= KIND_DONE;
            tx_byte     <= '0;
          end
          ACT_BAD: begin
            frame_phase <= PH_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  // Checks
  `LFT_ASSERT_NEXT(a_accept_dispatch, in_xfer, upc == U_DISP, "accepted item did not dispatch")
  `LFT_ASSERT_IMPL(a_zero_byte, out_valid && kind != KIND_BYTE, tx_byte == 8'd0,
                   "non-byte result carries a byte")
  `LFT_ASSERT_ALWAYS(a_count_range, sent_count <= MAX_PAYLOAD && sum_idx <= MAX_PAYLOAD,
                     "payload counter beyond buffer depth")
  `LFT_ASSERT_IMPL(a_stall_hold, stall, upc_next == upc, "step advanced while result blocked")

endmodule
